### rtl/core/pse_pkg.sv
// Package for the polynomial store and evaluator: sizes, codes, control word
// layout and the microcode table. Used by every module in rtl/core.
`timescale 1ns / 1ps

package pse_pkg;

  localparam int MAX_TERMS = 128;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_TERMS);

  typedef logic        [IDX_W-1:0] idx_t;
  typedef logic signed [IDX_W:0]   deg_t;
  typedef logic signed [7:0]       deg_out_t;
  typedef logic signed [31:0]      word_t;
  typedef logic signed [63:0]      wide_t;

  // Transaction kinds.
  localparam logic [2:0] KIND_CLEAR = 3'd0;
  localparam logic [2:0] KIND_LOAD  = 3'd1;
  localparam logic [2:0] KIND_ADD   = 3'd2;
  localparam logic [2:0] KIND_SUB   = 3'd3;
  localparam logic [2:0] KIND_EVAL  = 3'd4;

  // Microcode addresses.
  typedef logic [3:0] upc_t;
  localparam upc_t U_IDLE      = 4'd0;
  localparam upc_t U_CLEAR     = 4'd1;
  localparam upc_t U_LOAD      = 4'd2;
  localparam upc_t U_RMW_RD    = 4'd3;
  localparam upc_t U_RMW_WR    = 4'd4;
  localparam upc_t U_SCAN_INIT = 4'd5;
  localparam upc_t U_SCAN_RD   = 4'd6;
  localparam upc_t U_SCAN_CHK  = 4'd7;
  localparam upc_t U_FIN       = 4'd8;
  localparam upc_t U_EVAL_INIT = 4'd9;
  localparam upc_t U_EVAL_MUL  = 4'd10;
  localparam upc_t U_EVAL_ADD  = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_RMW_RD,
    OP_RMW_WR,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_EVAL_INIT,
    OP_EVAL_MUL,
    OP_EVAL_ADD,
    OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_GOTO,
    C_DISPATCH,
    C_IF_TOP_NEG,
    C_IF_DEG_NEG,
    C_IF_NOT_LAST,
    C_SCAN_LOOP,
    C_EVAL_LOOP,
    C_WAIT_OUT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  // Datapath flags seen by the sequencer.
  typedef struct packed {
    logic hit;
    logic ptr_zero;
    logic last;
    logic top_neg;
    logic deg_neg;
    logic out_free;
  } stat_t;

  // Coefficient store request.
  typedef struct packed {
    logic  clr;
    logic  we;
    idx_t  waddr;
    word_t wdata;
    idx_t  raddr;
  } mem_req_t;

  function automatic ctrl_t ucode(upc_t addr);
    ctrl_t w;
    unique case (addr)
      U_IDLE:      w = '{op: OP_NOP,       cond: C_DISPATCH,    target: U_IDLE};
      U_CLEAR:     w = '{op: OP_CLEAR,     cond: C_GOTO,        target: U_FIN};
      U_LOAD:      w = '{op: OP_LOAD,      cond: C_GOTO,        target: U_FIN};
      U_RMW_RD:    w = '{op: OP_RMW_RD,    cond: C_NEXT,        target: U_IDLE};
      U_RMW_WR:    w = '{op: OP_RMW_WR,    cond: C_IF_NOT_LAST, target: U_FIN};
      U_SCAN_INIT: w = '{op: OP_SCAN_INIT, cond: C_IF_TOP_NEG,  target: U_FIN};
      U_SCAN_RD:   w = '{op: OP_SCAN_RD,   cond: C_NEXT,        target: U_IDLE};
      U_SCAN_CHK:  w = '{op: OP_SCAN_CHK,  cond: C_SCAN_LOOP,   target: U_SCAN_RD};
      U_FIN:       w = '{op: OP_FINISH,    cond: C_WAIT_OUT,    target: U_IDLE};
      U_EVAL_INIT: w = '{op: OP_EVAL_INIT, cond: C_IF_DEG_NEG,  target: U_FIN};
      U_EVAL_MUL:  w = '{op: OP_EVAL_MUL,  cond: C_NEXT,        target: U_IDLE};
      U_EVAL_ADD:  w = '{op: OP_EVAL_ADD,  cond: C_EVAL_LOOP,   target: U_EVAL_MUL};
      default:     w = '{op: OP_NOP,       cond: C_GOTO,        target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/pse_coef_store.sv
// Coefficient memory with one write and one registered read port.
// A valid bit per entry makes unwritten or cleared entries read as zero. Uses pse_pkg.
`timescale 1ns / 1ps

module pse_coef_store (
  input  logic              clk,
  input  logic              rst_n,
  input  pse_pkg::mem_req_t req,
  output pse_pkg::word_t    rdata
);

  pse_pkg::word_t                   mem [pse_pkg::MAX_TERMS];
  logic [pse_pkg::MAX_TERMS-1:0]    vld_r;
  logic [pse_pkg::MAX_TERMS-1:0]    vld_nxt;
  pse_pkg::word_t                   rdata_r;
  logic                             rvld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (req.clr) begin
      vld_nxt = '0;
    end else if (req.we) begin
      vld_nxt[req.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
    rvld_r  <= vld_r[req.raddr];
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

### rtl/core/pse_sequencer.sv
// Microcode sequencer: step counter, control word lookup and jump logic.
// Depends on pse_pkg for the microcode table and the flag struct.
`timescale 1ns / 1ps

module pse_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [2:0]      in_kind,
  input  pse_pkg::stat_t  stat,
  output pse_pkg::ctrl_t  ctrl,
  output logic            in_stall
);

  pse_pkg::upc_t upc_r;
  pse_pkg::upc_t upc_nxt;
  pse_pkg::upc_t upc_inc;

  assign upc_inc = upc_r + 1'b1;

  always_comb begin
    ctrl     = pse_pkg::ucode(upc_r);
    in_stall = (upc_r != pse_pkg::U_IDLE);
  end

  always_comb begin
    upc_nxt = upc_r;
    unique case (ctrl.cond)
      pse_pkg::C_NEXT: upc_nxt = upc_inc;
      pse_pkg::C_GOTO: upc_nxt = ctrl.target;
      pse_pkg::C_DISPATCH: begin
        if (in_valid) begin
          unique case (in_kind)
            pse_pkg::KIND_CLEAR: upc_nxt = pse_pkg::U_CLEAR;
            pse_pkg::KIND_LOAD:  upc_nxt = pse_pkg::U_LOAD;
            pse_pkg::KIND_ADD,
            pse_pkg::KIND_SUB:   upc_nxt = pse_pkg::U_RMW_RD;
            pse_pkg::KIND_EVAL:  upc_nxt = pse_pkg::U_EVAL_INIT;
            default:             upc_nxt = pse_pkg::U_FIN;
          endcase
        end
      end
      pse_pkg::C_IF_TOP_NEG:  upc_nxt = stat.top_neg ? ctrl.target : upc_inc;
      pse_pkg::C_IF_DEG_NEG:  upc_nxt = stat.deg_neg ? ctrl.target : upc_inc;
      pse_pkg::C_IF_NOT_LAST: upc_nxt = !stat.last ? ctrl.target : upc_inc;
      pse_pkg::C_SCAN_LOOP: begin
        upc_nxt = (!stat.hit && !stat.ptr_zero) ? ctrl.target : pse_pkg::U_FIN;
      end
      pse_pkg::C_EVAL_LOOP: upc_nxt = !stat.ptr_zero ? ctrl.target : pse_pkg::U_FIN;
      pse_pkg::C_WAIT_OUT:  upc_nxt = stat.out_free ? ctrl.target : upc_r;
      default:              upc_nxt = pse_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= pse_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### rtl/core/pse_datapath.sv
// Datapath: transaction registers, degree tracking, Horner multiply-add with
// saturation, and the output register. Driven by pse_sequencer; uses pse_pkg.
`timescale 1ns / 1ps

module pse_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pse_pkg::ctrl_t       ctrl,
  input  logic                 in_fire,
  input  logic [2:0]           in_kind,
  input  logic [6:0]           in_term_index,
  input  logic signed [31:0]   in_coef_value,
  input  logic signed [31:0]   in_point,
  input  logic                 in_run_last,
  input  pse_pkg::word_t       mem_q,
  output pse_pkg::mem_req_t    mem_req,
  output pse_pkg::stat_t       stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_poly_value,
  output logic signed [7:0]    out_cur_degree,
  output logic                 out_saturated
);

  localparam pse_pkg::wide_t SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam pse_pkg::wide_t SAT_MIN = -64'sh0000_0000_8000_0000;

  // Transaction fields.
  logic [2:0]        kind_r;
  logic [6:0]        idx_r;
  pse_pkg::word_t    cv_r;
  pse_pkg::word_t    x_r;
  logic              last_r;

  // Working state.
  pse_pkg::word_t    acc_r,  acc_nxt;
  logic              clip_r, clip_nxt;
  pse_pkg::wide_t    prod_r, prod_nxt;
  pse_pkg::idx_t     ptr_r,  ptr_nxt;
  pse_pkg::deg_t     deg_r,  deg_nxt;
  pse_pkg::deg_t     rtop_r, rtop_nxt;

  // Output register.
  logic              ovld_r, ovld_nxt;
  pse_pkg::word_t    oval_r;
  pse_pkg::deg_out_t odeg_r;
  logic              osat_r;

  logic              inrange;
  pse_pkg::idx_t     widx;
  pse_pkg::deg_t     idx_s;
  pse_pkg::deg_t     top;
  logic signed [32:0] upd;
  pse_pkg::word_t    upd_sat;
  pse_pkg::wide_t    horner;
  logic              out_free;
  logic              out_load;

  assign inrange  = (32'(idx_r) < 32'(pse_pkg::MAX_TERMS));
  assign widx     = pse_pkg::idx_t'(idx_r);
  assign idx_s    = pse_pkg::deg_t'(idx_r);
  assign top      = (deg_r > rtop_r) ? deg_r : rtop_r;
  assign out_free = !ovld_r || !out_stall;
  assign out_load = (ctrl.op == pse_pkg::OP_FINISH) && out_free;

  assign upd = (kind_r == pse_pkg::KIND_SUB) ? (33'(mem_q) - 33'(cv_r))
                                             : (33'(mem_q) + 33'(cv_r));
  always_comb begin
    if (upd[32] != upd[31]) begin
      upd_sat = upd[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      upd_sat = upd[31:0];
    end
  end

  // The arithmetic shift rounds toward minus infinity.
  assign horner = (prod_r >>> pse_pkg::FRAC_BITS) + 64'(mem_q);

  always_comb begin
    stat.hit      = (mem_q != '0);
    stat.ptr_zero = (ptr_r == '0);
    stat.last     = last_r;
    stat.top_neg  = top[pse_pkg::IDX_W];
    stat.deg_neg  = deg_r[pse_pkg::IDX_W];
    stat.out_free = out_free;
  end

  always_comb begin
    mem_req.clr   = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = widx;
    mem_req.wdata = cv_r;
    mem_req.raddr = ptr_r;
    acc_nxt       = acc_r;
    clip_nxt      = clip_r;
    prod_nxt      = prod_r;
    ptr_nxt       = ptr_r;
    deg_nxt       = deg_r;
    rtop_nxt      = rtop_r;

    unique case (ctrl.op)
      pse_pkg::OP_NOP: begin
        if (in_fire) begin
          acc_nxt  = '0;
          clip_nxt = 1'b0;
        end
      end
      pse_pkg::OP_CLEAR: begin
        mem_req.clr = 1'b1;
        deg_nxt     = '1;
        rtop_nxt    = '1;
      end
      pse_pkg::OP_LOAD: begin
        if (inrange) begin
          mem_req.we = 1'b1;
          if (idx_s > deg_r) begin
            deg_nxt = idx_s;
          end
        end
      end
      pse_pkg::OP_RMW_RD: begin
        mem_req.raddr = widx;
      end
      pse_pkg::OP_RMW_WR: begin
        mem_req.wdata = upd_sat;
        if (inrange) begin
          mem_req.we = 1'b1;
          if (idx_s > rtop_r) begin
            rtop_nxt = idx_s;
          end
        end
      end
      pse_pkg::OP_SCAN_INIT: begin
        ptr_nxt  = pse_pkg::idx_t'(top);
        rtop_nxt = '1;
      end
      pse_pkg::OP_SCAN_RD: begin
        mem_req.raddr = ptr_r;
      end
      pse_pkg::OP_SCAN_CHK: begin
        priority if (mem_q != '0) begin
          deg_nxt = pse_pkg::deg_t'(ptr_r);
        end else if (ptr_r == '0) begin
          deg_nxt = '1;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      pse_pkg::OP_EVAL_INIT: begin
        ptr_nxt = pse_pkg::idx_t'(deg_r);
      end
      pse_pkg::OP_EVAL_MUL: begin
        mem_req.raddr = ptr_r;
        prod_nxt      = 64'(acc_r) * 64'(x_r);
      end
      pse_pkg::OP_EVAL_ADD: begin
        priority if (horner > SAT_MAX) begin
          acc_nxt  = 32'sh7FFF_FFFF;
          clip_nxt = 1'b1;
        end else if (horner < SAT_MIN) begin
          acc_nxt  = 32'sh8000_0000;
          clip_nxt = 1'b1;
        end else begin
          acc_nxt = horner[31:0];
        end
        if (ptr_r != '0) begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      pse_pkg::OP_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (out_load) begin
      ovld_nxt = 1'b1;
    end else if (!out_stall) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r  <= '1;
      rtop_r <= '1;
      ovld_r <= 1'b0;
    end else begin
      deg_r  <= deg_nxt;
      rtop_r <= rtop_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_kind;
      idx_r  <= in_term_index;
      cv_r   <= in_coef_value;
      x_r    <= in_point;
      last_r <= in_run_last;
    end
    acc_r  <= acc_nxt;
    clip_r <= clip_nxt;
    prod_r <= prod_nxt;
    ptr_r  <= ptr_nxt;
    if (out_load) begin
      oval_r <= acc_r;
      odeg_r <= pse_pkg::deg_out_t'(deg_r);
      osat_r <= clip_r;
    end
  end

  assign out_valid      = ovld_r;
  assign out_poly_value = oval_r;
  assign out_cur_degree = odeg_r;
  assign out_saturated  = osat_r;

endmodule

### rtl/core/polynomial_store_eval_unit.sv
// Top level of the polynomial store and evaluator. Instantiates pse_sequencer,
// pse_datapath and pse_coef_store; all types come from pse_pkg.
//
//   Channel | Ports                                                    | Dir
//   input   | in_valid, in_stall, in_kind, in_term_index,              | in
//           | in_coef_value, in_point, in_run_last                     |
//   result  | out_valid, out_stall, out_poly_value, out_cur_degree,    | out
//           | out_saturated                                            |
//
// One transaction is taken at a time; each gives exactly one result.
// Add or subtract rescans the store for the new degree when run_last is set.
// Evaluate runs Horner's rule from the degree down: each step multiplies in
// the multiplier, then shifts, adds and saturates.
// Reset is synchronous and clears the store at once through its valid bits.
// The result sits in an output register, so the next transaction is taken
// while a stalled result waits; the block only holds at its final step.
`timescale 1ns / 1ps

module polynomial_store_eval_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_kind,
  input  logic [6:0]          in_term_index,
  input  logic signed [31:0]  in_coef_value,
  input  logic signed [31:0]  in_point,
  input  logic                in_run_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_poly_value,
  output logic signed [7:0]   out_cur_degree,
  output logic                out_saturated
);

  pse_pkg::ctrl_t    ctrl;
  pse_pkg::stat_t    stat;
  pse_pkg::mem_req_t mem_req;
  pse_pkg::word_t    mem_q;
  logic              in_fire;

  assign in_fire = in_valid && !in_stall;

  pse_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  pse_coef_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_q)
  );

  pse_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_fire        (in_fire),
    .in_kind        (in_kind),
    .in_term_index  (in_term_index),
    .in_coef_value  (in_coef_value),
    .in_point       (in_point),
    .in_run_last    (in_run_last),
    .mem_q          (mem_q),
    .mem_req        (mem_req),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_poly_value (out_poly_value),
    .out_cur_degree (out_cur_degree),
    .out_saturated  (out_saturated)
  );

endmodule

### tb/tb_polynomial_store_eval_unit.sv
// Self-checking testbench for polynomial_store_eval_unit: directed and random
// transactions are predicted in place and checked field by field.
// Depends on pse_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_polynomial_store_eval_unit;

  localparam int             CLK_PERIOD   = 8;
  localparam int             RESET_CYCLES = 10;
  localparam int             PLANNED_OPS  = 1045;
  localparam int             TAIL_OPS     = 60;
  localparam int             DRAIN_CYCLES = 300;
  localparam int             CYCLE_LIMIT  = 2000000;
  localparam logic [2:0]     KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0]     KIND_SPARE_LAST  = 3'd7;
  localparam pse_pkg::word_t WORD_MAX = 32'sh7FFFFFFF;
  localparam pse_pkg::word_t WORD_MIN = 32'sh80000000;
  localparam pse_pkg::word_t Q_ONE    = 32'sh00010000;

  typedef struct {
    logic [2:0]     kind;
    logic [6:0]     term;
    pse_pkg::word_t coef;
    pse_pkg::word_t point;
    logic           last;
  } poly_op_t;

  typedef struct {
    pse_pkg::word_t    value;
    logic signed [7:0] degree;
    logic              clipped;
  } poly_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [2:0]          in_kind = '0;
  logic [6:0]          in_term_index = '0;
  logic signed [31:0]  in_coef_value = '0;
  logic signed [31:0]  in_point = '0;
  logic                in_run_last = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [31:0]  out_poly_value;
  logic signed [7:0]   out_cur_degree;
  logic                out_saturated;

  poly_op_t       pending_ops[$];
  poly_result_t   results_due[$];
  poly_op_t       cur_op;
  pse_pkg::word_t poly_coef [pse_pkg::MAX_TERMS];
  int             poly_degree = -1;
  int             poly_run_top = -1;
  int             err_count = 0;
  int             cycle_count = 0;
  int             src_gap = 0;
  int             src_calm = 0;
  int             sink_gap = 0;
  int             sink_calm = 0;
  logic           idling_on = 1'b1;

  polynomial_store_eval_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_term_index  (in_term_index),
    .in_coef_value  (in_coef_value),
    .in_point       (in_point),
    .in_run_last    (in_run_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_poly_value (out_poly_value),
    .out_cur_degree (out_cur_degree),
    .out_saturated  (out_saturated)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic pse_pkg::word_t clip_to_word(pse_pkg::wide_t v, output logic hit);
    hit = 1'b1;
    if (v > pse_pkg::wide_t'(WORD_MAX)) return WORD_MAX;
    if (v < pse_pkg::wide_t'(WORD_MIN)) return WORD_MIN;
    hit = 1'b0;
    return pse_pkg::word_t'(v);
  endfunction

  // Applies one transaction to the shadow polynomial and returns its result.
  function automatic poly_result_t apply_poly_op(poly_op_t op);
    poly_result_t   res;
    pse_pkg::wide_t wide;
    pse_pkg::word_t acc;
    logic           hit;
    int             top;
    int             found;
    res.value   = '0;
    res.clipped = 1'b0;
    case (op.kind)
      pse_pkg::KIND_CLEAR: begin
        foreach (poly_coef[i]) poly_coef[i] = '0;
        poly_degree  = -1;
        poly_run_top = -1;
      end
      pse_pkg::KIND_LOAD: begin
        poly_coef[op.term] = op.coef;
        if (int'(op.term) > poly_degree) poly_degree = int'(op.term);
      end
      pse_pkg::KIND_ADD, pse_pkg::KIND_SUB: begin
        if (op.kind == pse_pkg::KIND_ADD) begin
          wide = pse_pkg::wide_t'(poly_coef[op.term]) + pse_pkg::wide_t'(op.coef);
        end else begin
          wide = pse_pkg::wide_t'(poly_coef[op.term]) - pse_pkg::wide_t'(op.coef);
        end
        poly_coef[op.term] = clip_to_word(wide, hit);
        if (int'(op.term) > poly_run_top) poly_run_top = int'(op.term);
        if (op.last) begin
          top   = (poly_degree > poly_run_top) ? poly_degree : poly_run_top;
          found = -1;
          for (int i = top; i >= 0; i--) begin
            if (poly_coef[i] != 0) begin
              found = i;
              break;
            end
          end
          poly_degree  = found;
          poly_run_top = -1;
        end
      end
      pse_pkg::KIND_EVAL: begin
        acc = '0;
        for (int i = poly_degree; i >= 0; i--) begin
          wide = pse_pkg::wide_t'(acc) * pse_pkg::wide_t'(op.point);
          wide = wide >>> pse_pkg::FRAC_BITS;
          acc  = clip_to_word(wide + pse_pkg::wide_t'(poly_coef[i]), hit);
          res.clipped |= hit;
        end
        res.value = acc;
      end
      default: begin
      end
    endcase
    res.degree = 8'(poly_degree);
    return res;
  endfunction

  task automatic queue_op(logic [2:0] kind, logic [6:0] term, pse_pkg::word_t coef,
                          pse_pkg::word_t point, logic last);
    poly_op_t op;
    op.kind  = kind;
    op.term  = term;
    op.coef  = coef;
    op.point = point;
    op.last  = last;
    pending_ops.push_back(op);
  endtask

  function automatic pse_pkg::word_t rand_coef();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3, 4: return pse_pkg::word_t'($urandom);
      default: return pse_pkg::word_t'($urandom_range(0, 'h7FFFF)) - 32'sh40000;
    endcase
  endfunction

  function automatic pse_pkg::word_t rand_point();
    case ($urandom_range(0, 11))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return Q_ONE;
      3: return -Q_ONE;
      4: return '0;
      5: return pse_pkg::word_t'($urandom);
      default: return pse_pkg::word_t'($urandom_range(0, 'h3FFFF)) - 32'sh20000;
    endcase
  endfunction

  // Mostly low powers keep evaluation short; now and then anywhere in the store.
  function automatic logic [6:0] rand_term();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(0, pse_pkg::MAX_TERMS - 1));
    return 7'($urandom_range(0, 7));
  endfunction

  task automatic queue_eval();
    queue_op(pse_pkg::KIND_EVAL, 7'($urandom), pse_pkg::word_t'($urandom), rand_point(),
             1'($urandom));
  endtask

  task automatic plan_random_scenario();
    int             pick;
    int             n;
    logic [6:0]     term;
    pse_pkg::word_t coef;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      queue_op(pse_pkg::KIND_CLEAR, 7'($urandom), pse_pkg::word_t'($urandom),
               pse_pkg::word_t'($urandom), 1'($urandom));
    end else if (pick < 33) begin
      n = $urandom_range(1, 6);
      repeat (n) queue_op(pse_pkg::KIND_LOAD, rand_term(), rand_coef(),
                          pse_pkg::word_t'($urandom), 1'($urandom));
      queue_eval();
    end else if (pick < 65) begin
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 7) == 0) queue_eval();
        // A run now and then ends without its closing transaction.
        queue_op($urandom_range(0, 1) ? pse_pkg::KIND_ADD : pse_pkg::KIND_SUB, rand_term(),
                 rand_coef(), pse_pkg::word_t'($urandom),
                 (k == n - 1) && ($urandom_range(0, 9) != 0));
      end
      queue_eval();
    end else if (pick < 75) begin
      // Load a coefficient and cancel it, so the rescan has to walk down when it was the top.
      term = rand_term();
      coef = rand_coef();
      queue_op(pse_pkg::KIND_LOAD, term, coef, pse_pkg::word_t'($urandom), 1'($urandom));
      queue_eval();
      queue_op(pse_pkg::KIND_SUB, term, coef, pse_pkg::word_t'($urandom), 1'b1);
      queue_eval();
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 3)) queue_eval();
    end else if (pick < 95) begin
      queue_op(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), 7'($urandom),
               pse_pkg::word_t'($urandom), pse_pkg::word_t'($urandom), 1'($urandom));
    end else begin
      queue_op(3'($urandom), 7'($urandom), pse_pkg::word_t'($urandom),
               pse_pkg::word_t'($urandom), 1'($urandom));
    end
  endtask

  // Source side: presents queued transactions and predicts each accepted one.
  always @(posedge clk) begin : drive_proc
    logic drive_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      idling_on <= (pending_ops.size() > TAIL_OPS);
      if (in_valid && !in_stall) results_due.push_back(apply_poly_op(cur_op));
      if (!in_valid || !in_stall) begin
        drive_next = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_ops.size() > 0) begin
          if (src_calm > 0) src_calm--;
          else if ($urandom_range(0, 63) == 0) src_calm = $urandom_range(20, 200);
          if (idling_on && src_calm == 0 && $urandom_range(0, 11) == 0) begin
            src_gap = $urandom_range(0, 10);
          end else begin
            cur_op     = pending_ops.pop_front();
            drive_next = 1'b1;
          end
        end
        in_valid <= drive_next;
        if (drive_next) begin
          in_kind       <= cur_op.kind;
          in_term_index <= cur_op.term;
          in_coef_value <= cur_op.coef;
          in_point      <= cur_op.point;
          in_run_last   <= cur_op.last;
        end
      end
    end
  end

  // Result side: checks each accepted result and stalls in random bursts.
  always @(posedge clk) begin : sink_proc
    poly_result_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          err_count++;
          $display("%0t: result with no transaction outstanding, actual value %0d degree %0d",
                   $time, out_poly_value, out_cur_degree);
        end else begin
          due = results_due.pop_front();
          if (out_poly_value !== due.value) begin
            err_count++;
            $display("%0t: poly_value mismatch, expected %0d, actual %0d",
                     $time, due.value, out_poly_value);
          end
          if (out_cur_degree !== due.degree) begin
            err_count++;
            $display("%0t: cur_degree mismatch, expected %0d, actual %0d",
                     $time, due.degree, out_cur_degree);
          end
          if (out_saturated !== due.clipped) begin
            err_count++;
            $display("%0t: saturated mismatch, expected %0b, actual %0b",
                     $time, due.clipped, out_saturated);
          end
        end
      end
      if (sink_calm > 0) sink_calm--;
      else if ($urandom_range(0, 63) == 0) sink_calm = $urandom_range(20, 200);
      if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else if (idling_on && sink_calm == 0 && $urandom_range(0, 11) == 0) begin
        sink_gap  = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    foreach (poly_coef[i]) poly_coef[i] = '0;

    // Directed part: empty polynomial, extreme values, saturation, runs and spare kinds.
    queue_op(pse_pkg::KIND_EVAL, 7'd0, '0, Q_ONE, 1'b0);
    queue_op(pse_pkg::KIND_LOAD, 7'd0, WORD_MAX, '0, 1'b1);
    queue_op(pse_pkg::KIND_LOAD, 7'd127, WORD_MIN, '0, 1'b0);
    queue_op(pse_pkg::KIND_EVAL, 7'd127, WORD_MAX, WORD_MAX, 1'b1);
    queue_op(pse_pkg::KIND_EVAL, 7'd0, WORD_MIN, WORD_MIN, 1'b0);
    queue_op(pse_pkg::KIND_EVAL, 7'd0, '0, '0, 1'b0);
    queue_op(pse_pkg::KIND_ADD, 7'd0, 32'sd1, '0, 1'b0);
    queue_op(pse_pkg::KIND_SUB, 7'd127, 32'sd1, '0, 1'b0);
    queue_op(pse_pkg::KIND_EVAL, 7'd0, '0, Q_ONE, 1'b0);
    queue_op(pse_pkg::KIND_SUB, 7'd127, WORD_MIN, '0, 1'b1);
    queue_op(pse_pkg::KIND_EVAL, 7'd0, '0, -Q_ONE, 1'b0);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      queue_op(3'(k), 7'($urandom), pse_pkg::word_t'($urandom), pse_pkg::word_t'($urandom),
               1'($urandom));
    end
    queue_op(pse_pkg::KIND_CLEAR, 7'd127, WORD_MAX, WORD_MIN, 1'b1);
    queue_op(pse_pkg::KIND_ADD, 7'd5, 32'sh30000, '0, 1'b0);
    queue_op(pse_pkg::KIND_ADD, 7'd9, '0, '0, 1'b1);
    queue_op(pse_pkg::KIND_SUB, 7'd5, 32'sh30000, '0, 1'b1);
    queue_op(pse_pkg::KIND_ADD, 7'd0, '0, '0, 1'b1);
    queue_op(pse_pkg::KIND_LOAD, 7'd2, 32'sh18000, '0, 1'b0);
    queue_op(pse_pkg::KIND_LOAD, 7'd1, -32'sh20000, '0, 1'b0);
    queue_op(pse_pkg::KIND_LOAD, 7'd0, 32'sh4000, '0, 1'b0);
    queue_op(pse_pkg::KIND_EVAL, 7'd0, '0, -32'sh18000, 1'b0);
    queue_op(pse_pkg::KIND_EVAL, 7'd0, '0, 32'shFFFFFFFF, 1'b0);
    // A zero loaded above the top leaves a degree whose coefficient is zero.
    queue_op(pse_pkg::KIND_LOAD, 7'd3, '0, '0, 1'b0);
    queue_op(pse_pkg::KIND_EVAL, 7'd0, '0, 32'sh20000, 1'b0);
    queue_op(pse_pkg::KIND_CLEAR, 7'd0, '0, '0, 1'b0);
    queue_op(pse_pkg::KIND_EVAL, 7'd0, '0, WORD_MAX, 1'b0);

    while (pending_ops.size() < PLANNED_OPS) plan_random_scenario();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
